// ===== sv/gnlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnlp_pkg
// Shared types, field widths and reset values for the gradient noise block.
// ----------------------------------------------------------------------------
package gnlp_pkg;

   localparam int unsigned GRID_SIDE_DEF  = 64;
   localparam int unsigned POINT_SIDE_DEF = 4096;

   localparam int unsigned COL_W   = 6;
   localparam int unsigned GRAD_W  = 16;
   localparam int unsigned POINT_W = 12;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned CELL_W  = 9;
   localparam int unsigned STEP_W  = 16;
   localparam int unsigned LAST_W  = 6;
   localparam int unsigned SHIFT_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam int unsigned Q16_W    = 16;
   localparam int unsigned FADE_W   = 17;
   localparam int unsigned DOT_W    = 34;
   localparam int unsigned PROD_W   = 52;
   localparam int unsigned TOTAL_W  = 54;
   localparam int unsigned BLEND_SHIFT = 30;

   localparam int unsigned DIV_STAGES = 4;
   localparam int unsigned DIV_STEP   = POINT_W / DIV_STAGES;

   localparam logic [CELL_W-1:0]  CELL_SIZE_RST   = 9'd20;
   localparam logic [STEP_W-1:0]  OFFSET_STEP_RST = 16'd3121;
   localparam logic [LAST_W-1:0]  GRID_LAST_RST   = 6'd5;
   localparam logic [SHIFT_W-1:0] AMP_SHIFT_RST   = 4'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELL_SIZE   = 2'd0,
      CSR_OFFSET_STEP = 2'd1,
      CSR_GRID_LAST   = 2'd2,
      CSR_AMP_SHIFT   = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_NODE  = 1'b0,
      KIND_POINT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [COL_W-1:0]           col;
      logic [COL_W-1:0]           row;
      logic signed [GRAD_W-1:0]   gx;
      logic signed [GRAD_W-1:0]   gy;
   } node_type;

   typedef struct packed {
      logic [2:0] adv;
   } fade_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/gnlp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnlp_div
// Pipelined restoring divider: point coordinate by cell size, three quotient
// bits per stage, quotient and remainder out of the last stage.
// ----------------------------------------------------------------------------
module gnlp_div (
   input  wire logic                          clock,
   input  wire logic [gnlp_pkg::DIV_STAGES-1:0] adv,
   input  wire logic [gnlp_pkg::POINT_W-1:0]  dividend,
   input  wire logic [gnlp_pkg::CELL_W-1:0]   divisor,
   output logic      [gnlp_pkg::POINT_W-1:0]  quotient,
   output logic      [gnlp_pkg::CELL_W-1:0]   remainder
);

   logic [gnlp_pkg::POINT_W-1:0] num_ff [gnlp_pkg::DIV_STAGES];
   logic [gnlp_pkg::CELL_W-1:0]  rem_ff [gnlp_pkg::DIV_STAGES];
   logic [gnlp_pkg::POINT_W-1:0] num_in [gnlp_pkg::DIV_STAGES];
   logic [gnlp_pkg::CELL_W-1:0]  rem_in [gnlp_pkg::DIV_STAGES];

   always_comb begin
      logic [gnlp_pkg::POINT_W-1:0] n;
      logic [gnlp_pkg::CELL_W-1:0]  r;
      logic [gnlp_pkg::CELL_W:0]    t;
      for (int k = 0; k < gnlp_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            n = dividend;
            r = '0;
         end else begin
            n = num_ff[k-1];
            r = rem_ff[k-1];
         end
         for (int s = 0; s < gnlp_pkg::DIV_STEP; s++) begin
            t = {r, n[gnlp_pkg::POINT_W-1]};
            n = {n[gnlp_pkg::POINT_W-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
               t    = t - {1'b0, divisor};
               n[0] = 1'b1;
            end
            r = t[gnlp_pkg::CELL_W-1:0];
         end
         num_in[k] = n;
         rem_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < gnlp_pkg::DIV_STAGES; k++) begin
         if (adv[k]) begin
            num_ff[k] <= num_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign quotient  = num_ff[gnlp_pkg::DIV_STAGES-1];
   assign remainder = rem_ff[gnlp_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/gnlp_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnlp_fade
// Three-stage quintic fade 6t^5 - 15t^4 + 10t^3 on a Q0.16 offset.
// ----------------------------------------------------------------------------
module gnlp_fade (
   input  wire logic                          clock,
   input  wire gnlp_pkg::fade_ctrl_type       ctrl,
   input  wire logic [gnlp_pkg::Q16_W-1:0]    t,
   output logic      [gnlp_pkg::FADE_W-1:0]   f
);

   logic [15:0] t1_ff;
   logic [31:0] t2_ff;
   logic [31:0] t3h_ff;
   logic [19:0] qh_ff;
   logic [gnlp_pkg::FADE_W-1:0] f_ff;

   logic [47:0] t3;
   logic [36:0] q;
   logic [51:0] p;

   always_comb begin
      t3 = 48'(t2_ff) * 48'(t1_ff);
      q  = (37'(10) << 32) + 37'(t2_ff) * 37'(6) - ((37'(t1_ff) * 37'(15)) << 16);
      p  = 52'(t3h_ff) * 52'(qh_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         t1_ff <= t;
         t2_ff <= 32'(t) * 32'(t);
      end
      if (ctrl.adv[1]) begin
         t3h_ff <= t3[47:16];
         qh_ff  <= q[35:16];
      end
      if (ctrl.adv[2]) begin
         f_ff <= p[48:32];
      end
   end

   assign f = f_ff;

endmodule
`default_nettype wire

// ===== sv/gradient_noise_lattice_point.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_lattice_point
// One octave of fixed-point 2D gradient noise: stores lattice gradients and
// evaluates raster points, adding the scaled noise to a running sum.
//
//   channel | ports        | direction | carries
//   --------+--------------+-----------+--------------------------------------
//   request | req_*        | in        | node write or point evaluation
//   result  | rsp_*        | out       | saturated Q3.16 sum, point items only
//   config  | csr_*        | in        | cell size, offset step, grid, shift
//
// Thirteen register stages: input, four divider stages, offset, then three
// fade stages beside the gradient memory read and two dot product stages,
// weights, products, sum, output. One transaction per cycle unless the result stalls.
// Synchronous reset clears the valid bits and configuration; the gradient
// memory is not cleared. Each stage advances when it is empty or the next
// stage advances, so bubbles collapse under a result stall.
// ----------------------------------------------------------------------------
module gradient_noise_lattice_point #(
   parameter int unsigned GRID_SIDE  = gnlp_pkg::GRID_SIDE_DEF,
   parameter int unsigned POINT_SIDE = gnlp_pkg::POINT_SIDE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [gnlp_pkg::COL_W-1:0]        req_node_col,
   input  wire logic [gnlp_pkg::COL_W-1:0]        req_node_row,
   input  wire logic signed [gnlp_pkg::GRAD_W-1:0] req_grad_x,
   input  wire logic signed [gnlp_pkg::GRAD_W-1:0] req_grad_y,
   input  wire logic [gnlp_pkg::POINT_W-1:0]      req_point_x,
   input  wire logic [gnlp_pkg::POINT_W-1:0]      req_point_y,
   input  wire logic signed [gnlp_pkg::SUM_W-1:0] req_sum_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [gnlp_pkg::SUM_W-1:0]      rsp_sum_out,
   input  wire logic                              csr_we,
   input  wire logic [gnlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gnlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned NODE_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int unsigned AW = $clog2(NODE_COUNT);
   localparam int unsigned IW = $clog2(GRID_SIDE);
   localparam int unsigned NSTAGE = 13;
   localparam int unsigned S_DIV  = 4;
   localparam int unsigned S_OFS  = 5;
   localparam int unsigned S_MEM  = 6;
   localparam int unsigned S_DOT  = 7;
   localparam int unsigned S_FADE = 8;
   localparam int unsigned S_WGT  = 9;
   localparam int unsigned S_PROD = 10;
   localparam int unsigned S_TOT  = 11;
   localparam int unsigned S_OUT  = 12;
   localparam logic signed [24:0] ACC_MAX = 25'sd524287;
   localparam logic signed [24:0] ACC_MIN = -25'sd524288;
   localparam logic [gnlp_pkg::FADE_W-1:0] ONE_Q16 = 17'h10000;

   function automatic logic [AW-1:0] node_addr(input logic [IW-1:0] c,
                                                input logic [IW-1:0] r);
      node_addr = AW'(r) * AW'(GRID_SIDE) + AW'(c);
   endfunction

   // configuration
   logic [gnlp_pkg::CELL_W-1:0]  cell_size_ff;
   logic [gnlp_pkg::STEP_W-1:0]  offset_step_ff;
   logic [gnlp_pkg::LAST_W-1:0]  grid_last_ff;
   logic [gnlp_pkg::SHIFT_W-1:0] amp_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff   <= gnlp_pkg::CELL_SIZE_RST;
         offset_step_ff <= gnlp_pkg::OFFSET_STEP_RST;
         grid_last_ff   <= gnlp_pkg::GRID_LAST_RST;
         amp_shift_ff   <= gnlp_pkg::AMP_SHIFT_RST;
      end else if (csr_we) begin
         unique case (gnlp_pkg::csr_index_type'(csr_index))
            gnlp_pkg::CSR_CELL_SIZE:   cell_size_ff   <= csr_wdata[gnlp_pkg::CELL_W-1:0];
            gnlp_pkg::CSR_OFFSET_STEP: offset_step_ff <= csr_wdata;
            gnlp_pkg::CSR_GRID_LAST:   grid_last_ff   <= csr_wdata[gnlp_pkg::LAST_W-1:0];
            gnlp_pkg::CSR_AMP_SHIFT:   amp_shift_ff   <= csr_wdata[gnlp_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [gnlp_pkg::CELL_W-1:0] divisor;
   logic [IW-1:0]               last_c;

   always_comb begin
      divisor = (cell_size_ff == '0) ? gnlp_pkg::CELL_W'(1) : cell_size_ff;
      last_c  = (32'(grid_last_ff) > GRID_SIDE - 1) ? IW'(GRID_SIDE - 1)
                                                   : IW'(grid_last_ff);
   end

   // stage control
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] en_s;

   always_comb begin
      en_s[S_OUT] = !vld_ff[S_OUT] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en_s[k] = !vld_ff[k] || en_s[k+1];
      end
   end

   assign req_ready = en_s[0];

   gnlp_pkg::node_type node_ff [S_OFS];
   logic signed [gnlp_pkg::SUM_W-1:0] sum_ff [S_OUT];
   logic point_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en_s[k]) begin
               if (k == 0) begin
                  vld_ff[k] <= req_valid;
               end else if (k == S_MEM) begin
                  vld_ff[k] <= vld_ff[k-1] && point_ff;
               end else begin
                  vld_ff[k] <= vld_ff[k-1];
               end
            end
         end
      end
   end

   // stage 0: capture, clamp point to raster
   logic [gnlp_pkg::POINT_W-1:0] px0_ff;
   logic [gnlp_pkg::POINT_W-1:0] py0_ff;

   always_ff @(posedge clock) begin
      if (en_s[0]) begin
         node_ff[0] <= '{kind: gnlp_pkg::kind_type'(req_kind), col: req_node_col,
                         row: req_node_row, gx: req_grad_x, gy: req_grad_y};
         sum_ff[0]  <= req_sum_in;
         px0_ff <= (32'(req_point_x) > POINT_SIDE - 1) ?
                   gnlp_pkg::POINT_W'(POINT_SIDE - 1) : req_point_x;
         py0_ff <= (32'(req_point_y) > POINT_SIDE - 1) ?
                   gnlp_pkg::POINT_W'(POINT_SIDE - 1) : req_point_y;
      end
      for (int k = 1; k < S_OFS; k++) begin
         if (en_s[k]) node_ff[k] <= node_ff[k-1];
      end
      for (int k = 1; k < S_OUT; k++) begin
         if (en_s[k]) sum_ff[k] <= sum_ff[k-1];
      end
   end

   // stages 1..4: cell index and in-cell remainder
   logic [gnlp_pkg::POINT_W-1:0] qx, qy;
   logic [gnlp_pkg::CELL_W-1:0]  rx, ry;

   gnlp_div u_div_x (
      .clock     (clock),
      .adv       (en_s[S_DIV:1]),
      .dividend  (px0_ff),
      .divisor   (divisor),
      .quotient  (qx),
      .remainder (rx)
   );

   gnlp_div u_div_y (
      .clock     (clock),
      .adv       (en_s[S_DIV:1]),
      .dividend  (py0_ff),
      .divisor   (divisor),
      .quotient  (qy),
      .remainder (ry)
   );

   // stage 5: offsets and corner addresses
   logic [25:0]   ofs_px, ofs_py;
   logic [IW-1:0] c0, c1, r0, r1;
   logic          node_ok;

   always_comb begin
      ofs_px = 26'(offset_step_ff) * 26'({1'b0, rx} + 10'd1);
      ofs_py = 26'(offset_step_ff) * 26'({1'b0, ry} + 10'd1);
      c0 = (32'(qx) > 32'(last_c)) ? last_c : IW'(qx);
      c1 = (32'(qx) + 1 > 32'(last_c)) ? last_c : IW'(32'(qx) + 1);
      r0 = (32'(qy) > 32'(last_c)) ? last_c : IW'(qy);
      r1 = (32'(qy) + 1 > 32'(last_c)) ? last_c : IW'(32'(qy) + 1);
      node_ok = (32'(node_ff[S_DIV].col) < GRID_SIDE) &&
                (32'(node_ff[S_DIV].row) < GRID_SIDE);
   end

   logic [15:0]   u5_ff, v5_ff;
   logic [AW-1:0] rd_addr_ff [4];
   logic [AW-1:0] wr_addr_ff;
   logic [31:0]   wr_data_ff;
   logic          wr_ok_ff;

   always_ff @(posedge clock) begin
      if (en_s[S_OFS]) begin
         u5_ff <= (|ofs_px[25:16]) ? 16'hFFFF : ofs_px[15:0];
         v5_ff <= (|ofs_py[25:16]) ? 16'hFFFF : ofs_py[15:0];
         rd_addr_ff[0] <= node_addr(c0, r0);
         rd_addr_ff[1] <= node_addr(c0, r1);
         rd_addr_ff[2] <= node_addr(c1, r1);
         rd_addr_ff[3] <= node_addr(c1, r0);
         wr_addr_ff <= AW'(32'(node_ff[S_DIV].row) * GRID_SIDE + 32'(node_ff[S_DIV].col));
         wr_data_ff <= {node_ff[S_DIV].gy, node_ff[S_DIV].gx};
         wr_ok_ff   <= node_ok && (node_ff[S_DIV].kind == gnlp_pkg::KIND_NODE);
         point_ff   <= (node_ff[S_DIV].kind == gnlp_pkg::KIND_POINT);
      end
   end

   // stage 6: gradient memory, one copy per corner
   logic        wr_en;
   logic [31:0] grad_ff [4];
   logic [15:0] u6_ff, v6_ff;

   assign wr_en = en_s[S_MEM] && vld_ff[S_OFS] && wr_ok_ff;

   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [31:0] mem [NODE_COUNT];
      always_ff @(posedge clock) begin
         if (wr_en) mem[wr_addr_ff] <= wr_data_ff;
         if (en_s[S_MEM]) grad_ff[g] <= mem[rd_addr_ff[g]];
      end
   end

   always_ff @(posedge clock) begin
      if (en_s[S_MEM]) begin
         u6_ff <= u5_ff;
         v6_ff <= v5_ff;
      end
   end

   // stages 6..8: fade weights
   logic [gnlp_pkg::FADE_W-1:0] fu, fv;

   gnlp_fade u_fade_u (
      .clock (clock),
      .ctrl  ('{adv: en_s[S_FADE:S_MEM]}),
      .t     (u5_ff),
      .f     (fu)
   );

   gnlp_fade u_fade_v (
      .clock (clock),
      .ctrl  ('{adv: en_s[S_FADE:S_MEM]}),
      .t     (v5_ff),
      .f     (fv)
   );

   // stage 7: corner dot products
   logic signed [16:0] us, vs;
   logic signed [17:0] ucs, vcs;
   logic signed [15:0] gxs [4];
   logic signed [15:0] gys [4];
   logic signed [gnlp_pkg::DOT_W-1:0] dot [4];

   always_comb begin
      us  = $signed({1'b0, u6_ff});
      vs  = $signed({1'b0, v6_ff});
      ucs = $signed({1'b0, ONE_Q16 - {1'b0, u6_ff}});
      vcs = $signed({1'b0, ONE_Q16 - {1'b0, v6_ff}});
      for (int g = 0; g < 4; g++) begin
         gxs[g] = $signed(grad_ff[g][15:0]);
         gys[g] = $signed(grad_ff[g][31:16]);
      end
      dot[0] = us * gxs[0] + vs * gys[0];
      dot[1] = us * gxs[1] - vcs * gys[1];
      dot[2] = -(ucs * gxs[2]) - vcs * gys[2];
      dot[3] = -(ucs * gxs[3]) + vs * gys[3];
   end

   logic signed [gnlp_pkg::DOT_W-1:0] dot7_ff [4];
   logic signed [gnlp_pkg::DOT_W-1:0] dot8_ff [4];
   logic signed [gnlp_pkg::DOT_W-1:0] dot9_ff [4];

   // stage 9: joint weights
   logic [gnlp_pkg::FADE_W-1:0] gu, gv;
   logic [33:0] wp [4];

   always_comb begin
      gu = ONE_Q16 - fu;
      gv = ONE_Q16 - fv;
      wp[0] = 34'(gu) * 34'(gv);
      wp[1] = 34'(gu) * 34'(fv);
      wp[2] = 34'(fu) * 34'(fv);
      wp[3] = 34'(fu) * 34'(gv);
   end

   logic [gnlp_pkg::FADE_W-1:0] w_ff [4];
   logic signed [gnlp_pkg::PROD_W-1:0] prod_ff [4];
   logic signed [gnlp_pkg::PROD_W-1:0] prod [4];

   always_comb begin
      for (int g = 0; g < 4; g++) begin
         prod[g] = $signed({1'b0, w_ff[g]}) * dot9_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < 4; g++) begin
         if (en_s[S_DOT])  dot7_ff[g] <= dot[g];
         if (en_s[S_FADE]) dot8_ff[g] <= dot7_ff[g];
         if (en_s[S_WGT]) begin
            dot9_ff[g] <= dot8_ff[g];
            w_ff[g]    <= wp[g][32:16];
         end
         if (en_s[S_PROD]) prod_ff[g] <= prod[g];
      end
   end

   // stage 11: blend sum; stage 12: scale, accumulate, saturate
   logic signed [gnlp_pkg::TOTAL_W-1:0] total_ff;
   logic signed [gnlp_pkg::TOTAL_W-1:0] shifted;
   logic [5:0]                          shamt;
   logic signed [24:0]                  acc;
   logic signed [gnlp_pkg::SUM_W-1:0]   out_ff;
   logic signed [gnlp_pkg::SUM_W-1:0]   sat;

   always_comb begin
      shamt   = 6'(gnlp_pkg::BLEND_SHIFT) + {2'b00, amp_shift_ff};
      shifted = total_ff >>> shamt;
      acc     = $signed(shifted[24:0]) +
                $signed({{5{sum_ff[S_TOT][gnlp_pkg::SUM_W-1]}}, sum_ff[S_TOT]});
      priority if (acc > ACC_MAX) begin
         sat = 20'sh7FFFF;
      end else if (acc < ACC_MIN) begin
         sat = 20'sh80000;
      end else begin
         sat = acc[gnlp_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_s[S_TOT]) begin
         total_ff <= gnlp_pkg::TOTAL_W'(prod_ff[0]) + gnlp_pkg::TOTAL_W'(prod_ff[1]) +
                     gnlp_pkg::TOTAL_W'(prod_ff[2]) + gnlp_pkg::TOTAL_W'(prod_ff[3]);
      end
      if (en_s[S_OUT]) out_ff <= sat;
   end

   assign rsp_valid   = vld_ff[S_OUT];
   assign rsp_sum_out = out_ff;

   // checks
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&vld_ff))
      else $error("input stalled with an empty stage in the pipe");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[S_WGT] && !en_s[S_WGT]) |=> vld_ff[S_WGT])
      else $error("stalled weight stage lost its transaction");

   a_node_drops: assert property (@(posedge clock) disable iff (reset)
      (en_s[S_MEM] && vld_ff[S_OFS] && wr_ok_ff) |=> !vld_ff[S_MEM])
      else $error("node write continued past the memory stage");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_PROD - 1] |-> (19'(w_ff[0]) + 19'(w_ff[1]) + 19'(w_ff[2]) +
                              19'(w_ff[3]) <= 19'(ONE_Q16)))
      else $error("fade weights exceed one");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      divisor != '0)
      else $error("zero divisor");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gradient_noise_lattice_point. It writes lattice
// gradients, evaluates raster points under several register settings, predicts each
// Q3.16 sum in a scoreboard and compares every result in order.
// ----------------------------------------------------------------------------
module testbench;
   import gnlp_pkg::*;

   class noise_scoreboard;
      logic [31:0]              grad_mem [0:4095];
      logic [CELL_W-1:0]        cell_sz;
      logic [STEP_W-1:0]        step;
      logic [LAST_W-1:0]        last;
      logic [SHIFT_W-1:0]       shift;
      logic signed [SUM_W-1:0]  expected_sums [$];
      int                       errors;
      int                       points;
      int                       nodes;
      int                       checked;

      function void load_reset_values();
         cell_sz = CELL_SIZE_RST;
         step    = OFFSET_STEP_RST;
         last    = GRID_LAST_RST;
         shift   = AMP_SHIFT_RST;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CELL_SIZE:   cell_sz = data[CELL_W-1:0];
            CSR_OFFSET_STEP: step    = data[STEP_W-1:0];
            CSR_GRID_LAST:   last    = data[LAST_W-1:0];
            CSR_AMP_SHIFT:   shift   = data[SHIFT_W-1:0];
         endcase
      endfunction

      function longint divisor();
         return (cell_sz == 0) ? 1 : longint'(cell_sz);
      endfunction

      function int node_index(int p, int add);
         longint n;
         n = longint'(p) / divisor() + add;
         return (n > longint'(last)) ? int'(last) : int'(n);
      endfunction

      function longint offset(longint rem);
         longint prod;
         prod = longint'(step) * (rem + 1);
         return (prod > 65535) ? 65535 : prod;
      endfunction

      function longint fade(longint t);
         longint cube;
         longint poly;
         cube = t * t * t;
         poly = (longint'(10) << 32) + 6 * t * t - ((15 * t) << 16);
         return ((cube >> 16) * (poly >> 16)) >> 32;
      endfunction

      function longint grad_x(int c, int r);
         return longint'($signed(grad_mem[r * 64 + c][15:0]));
      endfunction

      function longint grad_y(int c, int r);
         return longint'($signed(grad_mem[r * 64 + c][31:16]));
      endfunction

      function logic signed [SUM_W-1:0] predict_sum(int px, int py,
                                                    logic signed [SUM_W-1:0] sum_in);
         int     c0, c1, r0, r1;
         longint u, v, uc, vc, fu, fv, gu, gv, total, sum;
         longint dbl, dul, dur, dbr;
         c0 = node_index(px, 0);
         c1 = node_index(px, 1);
         r0 = node_index(py, 0);
         r1 = node_index(py, 1);
         u  = offset(longint'(px) % divisor());
         v  = offset(longint'(py) % divisor());
         uc = 65536 - u;
         vc = 65536 - v;
         dbl = u * grad_x(c0, r0) + v * grad_y(c0, r0);
         dul = u * grad_x(c0, r1) - vc * grad_y(c0, r1);
         dur = -uc * grad_x(c1, r1) - vc * grad_y(c1, r1);
         dbr = -uc * grad_x(c1, r0) + v * grad_y(c1, r0);
         fu = fade(u);
         fv = fade(v);
         gu = 65536 - fu;
         gv = 65536 - fv;
         total = ((gu * gv) >> 16) * dbl + ((gu * fv) >> 16) * dul
               + ((fu * fv) >> 16) * dur + ((fu * gv) >> 16) * dbr;
         sum = longint'(sum_in) + (total >>> (BLEND_SHIFT + shift));
         if (sum > 524287) sum = 524287;
         if (sum < -524288) sum = -524288;
         return sum[SUM_W-1:0];
      endfunction

      function void note_request(kind_type kind, int col, int row,
                                 logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy,
                                 int px, int py, logic signed [SUM_W-1:0] sum_in);
         if (kind == KIND_NODE) begin
            grad_mem[row * 64 + col] = {gy, gx};
            nodes++;
         end else begin
            expected_sums.push_back(predict_sum(px, py, sum_in));
            points++;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic signed [SUM_W-1:0] got);
         logic signed [SUM_W-1:0] want;
         if (expected_sums.size() == 0) begin
            report($sformatf("unexpected result sum_out=%0d", got));
         end else begin
            want = expected_sums.pop_front();
            checked++;
            if (got !== want)
               report($sformatf("sum_out=%0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_kind;
   logic [COL_W-1:0]           req_node_col;
   logic [COL_W-1:0]           req_node_row;
   logic signed [GRAD_W-1:0]   req_grad_x;
   logic signed [GRAD_W-1:0]   req_grad_y;
   logic [POINT_W-1:0]         req_point_x;
   logic [POINT_W-1:0]         req_point_y;
   logic signed [SUM_W-1:0]    req_sum_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SUM_W-1:0]    rsp_sum_out;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   noise_scoreboard sb;
   bit   written [0:4095];
   bit   quiet;
   int   idle_cycles;
   int   stall_left;
   int   config_writes;

   gradient_noise_lattice_point i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_node_col(req_node_col),
      .req_node_row(req_node_row),
      .req_grad_x  (req_grad_x),
      .req_grad_y  (req_grad_y),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_sum_in  (req_sum_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sum_out (rsp_sum_out),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(kind_type'(req_kind), req_node_col, req_node_row, req_grad_x,
                            req_grad_y, req_point_x, req_point_y, req_sum_in);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_sum_out);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("** gradient_noise_lattice_point: FAILED **");
            $finish;
         end
      end
   end

   // result-side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
      end
   end

   task automatic send(kind_type kind, int col, int row, logic [GRAD_W-1:0] gx,
                       logic [GRAD_W-1:0] gy, int px, int py,
                       logic [SUM_W-1:0] sum_in);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_kind     = kind;
      req_node_col = col;
      req_node_row = row;
      req_grad_x   = gx;
      req_grad_y   = gy;
      req_point_x  = px;
      req_point_y  = py;
      req_sum_in   = sum_in;
      if (kind == KIND_NODE) written[row * 64 + col] = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_node(int col, int row, logic [GRAD_W-1:0] gx,
                             logic [GRAD_W-1:0] gy);
      send(KIND_NODE, col, row, gx, gy, $urandom_range(0, 4095), $urandom_range(0, 4095),
           $urandom);
   endtask

   function automatic logic [GRAD_W-1:0] random_grad();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   function automatic bit corners_ready(int px, int py);
      return written[sb.node_index(py, 0) * 64 + sb.node_index(px, 0)]
          && written[sb.node_index(py, 1) * 64 + sb.node_index(px, 0)]
          && written[sb.node_index(py, 0) * 64 + sb.node_index(px, 1)]
          && written[sb.node_index(py, 1) * 64 + sb.node_index(px, 1)];
   endfunction

   function automatic logic [SUM_W-1:0] random_sum();
      case ($urandom_range(0, 7))
         0:       return 20'h7FFFF - $urandom_range(0, 3);
         1:       return 20'h80000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // evaluate a point whose four corners hold written gradients
   task automatic eval_point(int px, int py, logic [SUM_W-1:0] sum_in);
      int tries;
      tries = 0;
      while (!corners_ready(px, py) && tries < 60) begin
         px = $urandom_range(0, 4095);
         py = $urandom_range(0, 4095);
         tries++;
      end
      if (!corners_ready(px, py)) begin
         px = 0;
         py = 0;
      end
      send(KIND_POINT, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom,
           px, py, sum_in);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_sums.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.set_register(idx, data);
      config_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_all(int cell_sz, int step, int last, int shift);
      write_csr(CSR_CELL_SIZE, cell_sz);
      write_csr(CSR_OFFSET_STEP, step);
      write_csr(CSR_GRID_LAST, last);
      write_csr(CSR_AMP_SHIFT, shift);
   endtask

   task automatic random_run(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 3)
            write_node($urandom_range(0, 63), $urandom_range(0, 63), random_grad(),
                       random_grad());
         else if ($urandom_range(0, 9) == 0)
            eval_point($urandom_range(0, 1) ? 0 : 4095, $urandom_range(0, 4095),
                       random_sum());
         else
            eval_point($urandom_range(0, 4095), $urandom_range(0, 4095), random_sum());
      end
   endtask

   initial begin
      sb = new();
      sb.load_reset_values();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_NODE;
      req_node_col = '0;
      req_node_row = '0;
      req_grad_x   = '0;
      req_grad_y   = '0;
      req_point_x  = '0;
      req_point_y  = '0;
      req_sum_in   = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_CELL_SIZE;
      csr_wdata    = '0;
      quiet        = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: gradient extremes, then points in the first cell and sum limits
      write_node(0, 0, 16'sh7FFF, 16'sh8000);
      write_node(1, 0, 16'sd16384, -16'sd16384);
      write_node(0, 1, -16'sd16384, 16'sd16384);
      write_node(1, 1, 16'sh8000, 16'sh7FFF);
      eval_point(0, 0, 20'h7FFFF);
      eval_point(0, 0, 20'h80000);
      eval_point(19, 19, 20'h00000);
      eval_point(10, 3, 20'h7FFFF);
      eval_point(7, 12, 20'h80000);
      write_node(1, 1, 16'sd0, 16'sd0);
      eval_point(19, 19, 20'hFFFFF);

      // fill the low grid plus the far row and column
      for (int r = 0; r <= 16; r++)
         for (int c = 0; c <= 16; c++)
            write_node(c, r, random_grad(), random_grad());
      for (int i = 0; i < 64; i++) begin
         write_node(i, 63, random_grad(), random_grad());
         write_node(63, i, random_grad(), random_grad());
      end
      eval_point(4095, 4095, 20'h7FFFF);
      eval_point(0, 4095, 20'h80000);
      eval_point(4095, 0, 20'h12345);
      random_run(150);

      set_all(1, 32768, 63, 15);
      eval_point(4095, 4095, 20'h7FFFF);
      eval_point(0, 0, 20'h80000);
      random_run(150);
      set_all(256, 255, 63, 0);
      eval_point(255, 255, 20'h7FFFF);
      eval_point(4095, 4095, 20'h80000);
      random_run(150);
      set_all(0, 65535, 1, 0);
      random_run(100);
      set_all(40, 1, 16, 7);
      random_run(150);
      set_all(9, 6554, 16, 1);
      random_run(150);
      for (int k = 0; k < 3; k++) begin
         set_all($urandom_range(0, 511), $urandom_range(0, 65535), $urandom_range(0, 63),
                 $urandom_range(0, 15));
         random_run(100);
      end
      set_all(20, 3121, 5, 0);
      quiet = 1'b1;
      random_run(150);

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_sums.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      $display("covered %0d node writes, %0d point evaluations (%0d checked), %0d csr writes",
               sb.nodes, sb.points, sb.checked, config_writes);
      if (sb.errors == 0) begin
         $display("** gradient_noise_lattice_point: PASSED **");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("** gradient_noise_lattice_point: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/gnlp_pkg.sv
sv/gnlp_div.sv
sv/gnlp_fade.sv
sv/gradient_noise_lattice_point.sv
tb/testbench.sv
